// ===== rtl/core/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and decode helpers for the JSON string
// unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Result kinds carried on the output word
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Most results one source byte can cause (three-byte UTF-8 sequence)
  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] ChrNul       = 8'h00;
  localparam logic [7:0] ChrQuote     = 8'h22;
  localparam logic [7:0] ChrBackslash = 8'h5C;
  localparam logic [7:0] ChrSlash     = 8'h2F;
  localparam logic [7:0] ChrLowerU    = 8'h75;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Cont  = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } res_t;

  // {valid, value} of one hex digit, either case
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // {valid, byte} of a single-character escape
  function automatic logic [8:0] esc_val(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      ChrQuote:     r = {1'b1, ChrQuote};
      ChrBackslash: r = {1'b1, ChrBackslash};
      ChrSlash:     r = {1'b1, ChrSlash};
      8'h62:        r = {1'b1, 8'h08};
      8'h66:        r = {1'b1, 8'h0C};
      8'h6E:        r = {1'b1, 8'h0A};
      8'h72:        r = {1'b1, 8'h0D};
      8'h74:        r = {1'b1, 8'h09};
      default:      r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/jsu_if.sv =====
// ----------------------------------------------------------------------------
// jsu_if
// Valid/ready channels of the JSON string unescaper: source bytes in,
// decoded result words out.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
  logic          valid;
  logic          ready;
  logic [7:0]    out_byte;
  jsu_pkg::kind_e kind;
  logic          last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ===== rtl/core/json_string_unescaper.sv =====
// ----------------------------------------------------------------------------
// json_string_unescaper
// The first result word of a source byte appears on the output in the cycle
// after that byte is taken. One source byte is taken per cycle while the output
// is ready; a \uXXXX that encodes to 2 or 3 UTF-8 bytes holds the input
// while the result slots drain, one word per cycle.
// Reset (rst_ni low, asynchronous): waiting for an opening quote, no results.
// ----------------------------------------------------------------------------
module json_string_unescaper (
  input  logic             clk_i,
  input  logic             rst_ni,
  jsu_in_if.sink           in_i,
  jsu_out_if.source        out_o
);

  // Decoder modes. Anything outside the list behaves as waiting for a quote.
  typedef enum logic [2:0] {
    M_WAIT = 3'd0,
    M_BODY = 3'd1,
    M_ESC  = 3'd2,
    M_HEX0 = 3'd3,
    M_HEX1 = 3'd4,
    M_HEX2 = 3'd5,
    M_HEX3 = 3'd6
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [11:0]       accum_q, accum_d;   // hex digits taken so far
  logic [1:0]        cnt_q;              // result words still waiting
  logic [1:0]        n_res;              // words caused by the current byte
  jsu_pkg::res_t     slot_q [jsu_pkg::MaxResults];
  jsu_pkg::res_t     slot_d [jsu_pkg::MaxResults];

  logic              acc, pop;
  logic              marker;             // done/error ends the string
  jsu_pkg::kind_e    marker_kind;
  logic [4:0]        hex;
  logic [8:0]        esc;
  logic [15:0]       cp;
  logic [7:0]        c;

  // Take a byte when the slots are empty, or when the only waiting word
  // leaves in this same cycle. The result slots act as the output register.
  assign in_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);
  assign acc        = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  assign out_o.valid    = (cnt_q != 2'd0);
  assign out_o.out_byte = slot_q[0].data;
  assign out_o.kind     = slot_q[0].kind;
  assign out_o.last     = slot_q[0].last;

  assign c   = in_i.in_byte;
  assign hex = jsu_pkg::hex_val(c);
  assign esc = jsu_pkg::esc_val(c);
  assign cp  = {accum_q, hex[3:0]};

  // Single-pass decode of one source byte
  always_comb begin
    mode_d      = mode_q;
    accum_d     = accum_q;
    n_res       = 2'd0;
    marker      = 1'b0;
    marker_kind = jsu_pkg::KIND_ERROR;
    for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
      slot_d[i] = '{data: 8'h00, kind: jsu_pkg::KIND_DATA, last: 1'b0};
    end

    case (mode_q)
      M_BODY: begin
        if (c == jsu_pkg::ChrNul) begin
          marker = 1'b1;
        end else if (c == jsu_pkg::ChrQuote) begin
          marker      = 1'b1;
          marker_kind = jsu_pkg::KIND_DONE;
        end else if (c == jsu_pkg::ChrBackslash) begin
          mode_d = M_ESC;
        end else begin
          slot_d[0].data = c;
          n_res          = 2'd1;
        end
      end

      M_ESC: begin
        if (c == jsu_pkg::ChrLowerU) begin
          mode_d  = M_HEX0;
          accum_d = 12'h000;
        end else if (esc[8]) begin
          mode_d         = M_BODY;
          slot_d[0].data = esc[7:0];
          n_res          = 2'd1;
        end else begin
          marker = 1'b1;
        end
      end

      M_HEX0, M_HEX1, M_HEX2: begin
        if (!hex[4]) begin
          marker = 1'b1;
        end else begin
          accum_d = {accum_q[7:0], hex[3:0]};
          mode_d  = mode_e'(mode_q + 3'd1);
        end
      end

      M_HEX3: begin
        if (!hex[4]) begin
          marker = 1'b1;
        end else begin
          mode_d  = M_BODY;
          accum_d = 12'h000;
          if (cp[15:7] == 9'd0) begin
            slot_d[0].data = cp[7:0];
            n_res          = 2'd1;
          end else if (cp[15:11] == 5'd0) begin
            slot_d[0].data = jsu_pkg::Utf8Lead2 | {3'b000, cp[10:6]};
            slot_d[1].data = jsu_pkg::Utf8Cont | {2'b00, cp[5:0]};
            n_res          = 2'd2;
          end else begin
            slot_d[0].data = jsu_pkg::Utf8Lead3 | {4'h0, cp[15:12]};
            slot_d[1].data = jsu_pkg::Utf8Cont | {2'b00, cp[11:6]};
            slot_d[2].data = jsu_pkg::Utf8Cont | {2'b00, cp[5:0]};
            n_res          = 2'd3;
          end
        end
      end

      default: begin
        // waiting for the opening quote
        if (c == jsu_pkg::ChrQuote) begin
          mode_d  = M_BODY;
          accum_d = 12'h000;
        end else begin
          marker = 1'b1;
        end
      end
    endcase

    if (marker) begin
      mode_d         = M_WAIT;
      accum_d        = 12'h000;
      slot_d[0].kind = marker_kind;
      n_res          = 2'd1;
    end

    // flag the final word of this byte
    for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
      slot_d[i].last = (n_res == 2'(i + 1));
    end
  end

  // Decoder state and result slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_WAIT;
      accum_q <= 12'h000;
      cnt_q   <= 2'd0;
      for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
        slot_q[i] <= '{data: 8'h00, kind: jsu_pkg::KIND_DATA, last: 1'b0};
      end
    end else if (acc) begin
      mode_q  <= mode_d;
      accum_q <= accum_d;
      cnt_q   <= n_res;
      for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
        slot_q[i] <= slot_d[i];
      end
    end else if (pop) begin
      // shift the next waiting word to the head
      cnt_q <= cnt_q - 2'd1;
      for (int i = 0; i < jsu_pkg::MaxResults - 1; i++) begin
        slot_q[i] <= slot_q[i + 1];
      end
    end
  end

endmodule
